[sv/clsc_pkg.sv]
// shared types, character constants and recognizer functions for the syntax checker
package clsc_pkg;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DASH   = 8'h2D;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [3:0] {
		CL_SPACE,
		CL_ALPHA,
		CL_PIPE,
		CL_AMP,
		CL_LT,
		CL_GT,
		CL_DOLLAR,
		CL_DOT,
		CL_SLASH,
		CL_DASH,
		CL_OTHER
	} cls_t;

	typedef enum logic [4:0] {
		ST_LEAD   = 5'd0,
		ST_CMD    = 5'd1,
		ST_GAP    = 5'd2,
		ST_OPTSEP = 5'd3,
		ST_OPT    = 5'd4,
		ST_AMP1   = 5'd5,
		ST_AMP2   = 5'd6,
		ST_AMPSP  = 5'd7,
		ST_AMPCMD = 5'd8,
		ST_PIPE1  = 5'd9,
		ST_PIPE2  = 5'd10,
		ST_PIPESP = 5'd11,
		ST_WORD   = 5'd12,
		ST_PATH   = 5'd13,
		ST_EXT    = 5'd14,
		ST_RFILE  = 5'd15,
		ST_RSP    = 5'd16,
		ST_LT     = 5'd17,
		ST_GT     = 5'd18,
		ST_HDOC   = 5'd19,
		ST_HDWORD = 5'd20,
		ST_FEXT   = 5'd21,
		ST_DOT    = 5'd22,
		ST_DOTDOT = 5'd23,
		ST_REL    = 5'd24,
		ST_VAR    = 5'd25,
		ST_FAIL   = 5'd26
	} state_t;

	// classified character word passed from front to back
	typedef struct packed {
		cls_t cls;
		logic last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		r = CL_OTHER;
		if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) r = CL_ALPHA;
		else begin
			case (c)
				CH_SPACE:  r = CL_SPACE;
				CH_PIPE:   r = CL_PIPE;
				CH_AMP:    r = CL_AMP;
				CH_LT:     r = CL_LT;
				CH_GT:     r = CL_GT;
				CH_DOLLAR: r = CL_DOLLAR;
				CH_DOT:    r = CL_DOT;
				CH_SLASH:  r = CL_SLASH;
				CH_DASH:   r = CL_DASH;
				default:   r = CL_OTHER;
			endcase
		end
		return r;
	endfunction

	function automatic state_t next_state(input state_t s, input cls_t k);
		state_t n;
		logic a;
		logic sp;
		a  = (k == CL_ALPHA);
		sp = (k == CL_SPACE);
		n  = ST_FAIL;
		case (s)
			ST_LEAD:   n = sp ? ST_LEAD : (a ? ST_CMD : ST_FAIL);
			ST_CMD:    n = sp ? ST_GAP : (a ? ST_CMD : ST_FAIL);
			ST_GAP: begin
				case (k)
					CL_DASH:   n = ST_OPT;
					CL_SPACE:  n = ST_GAP;
					CL_PIPE:   n = ST_PIPE1;
					CL_LT:     n = ST_LT;
					CL_GT:     n = ST_GT;
					CL_AMP:    n = ST_AMP1;
					CL_ALPHA:  n = ST_WORD;
					CL_DOT:    n = ST_DOT;
					CL_DOLLAR: n = ST_VAR;
					default:   n = ST_FAIL;
				endcase
			end
			ST_OPTSEP: n = sp ? ST_OPT : ST_FAIL;
			ST_OPT:    n = sp ? ST_GAP : (a ? ST_OPT : ST_FAIL);
			ST_AMP1:   n = (k == CL_AMP) ? ST_AMP2 : ST_FAIL;
			ST_AMP2:   n = sp ? ST_AMPSP : ST_FAIL;
			ST_AMPSP:  n = a ? ST_AMPCMD : ST_FAIL;
			ST_AMPCMD: n = sp ? ST_GAP : (a ? ST_AMPCMD : ST_FAIL);
			ST_PIPE1:  n = sp ? ST_PIPESP : ((k == CL_PIPE) ? ST_PIPE2 : ST_FAIL);
			ST_PIPE2:  n = sp ? ST_PIPESP : ST_FAIL;
			ST_PIPESP: n = a ? ST_WORD : ST_FAIL;
			ST_WORD: begin
				case (k)
					CL_SPACE: n = ST_GAP;
					CL_SLASH: n = ST_PATH;
					CL_ALPHA: n = ST_WORD;
					CL_DOT:   n = ST_EXT;
					default:  n = ST_FAIL;
				endcase
			end
			ST_PATH:   n = a ? ST_PATH : ((k == CL_DOT) ? ST_EXT : ST_FAIL);
			ST_EXT:    n = a ? ST_EXT : (sp ? ST_GAP : ST_FAIL);
			ST_RFILE: begin
				case (k)
					CL_DOT:   n = ST_FEXT;
					CL_SLASH: n = ST_RFILE;
					CL_ALPHA: n = ST_RFILE;
					default:  n = ST_FAIL;
				endcase
			end
			ST_RSP:    n = (sp || a) ? ST_RFILE : ST_FAIL;
			ST_LT:     n = (k == CL_LT) ? ST_HDOC : (sp ? ST_RSP : ST_FAIL);
			ST_GT:     n = (k == CL_GT) ? ST_RSP : (sp ? ST_RFILE : ST_FAIL);
			ST_HDOC:   n = sp ? ST_HDWORD : ST_FAIL;
			ST_HDWORD: n = (k == CL_DOT) ? ST_FEXT : (a ? ST_HDWORD : ST_FAIL);
			ST_FEXT:   n = a ? ST_FEXT : ST_FAIL;
			ST_DOT: begin
				case (k)
					CL_DOT:   n = ST_DOTDOT;
					CL_SLASH: n = ST_REL;
					CL_SPACE: n = ST_GAP;
					CL_ALPHA: n = ST_GAP;
					default:  n = ST_FAIL;
				endcase
			end
			ST_DOTDOT: n = (k == CL_SLASH) ? ST_REL : (sp ? ST_GAP : ST_FAIL);
			ST_REL:    n = sp ? ST_GAP : (a ? ST_WORD : ST_FAIL);
			ST_VAR:    n = a ? ST_WORD : ST_FAIL;
			default:   n = ST_FAIL;
		endcase
		return n;
	endfunction

endpackage

[sv/clsc_front.sv]
// front stage: accepts input words and registers their character class
module clsc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         ch,
	input  logic               last,
	input  clsc_pkg::qstat_t   qstat,
	output logic               push,
	output clsc_pkg::item_t    item
);

	logic            valid_s1;
	clsc_pkg::item_t item_s1;
	logic            load;

	assign in_stall = valid_s1 && qstat.full;
	assign load     = in_valid && !in_stall;
	assign push     = valid_s1 && !qstat.full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load || (valid_s1 && qstat.full);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.cls  <= clsc_pkg::classify(ch);
			item_s1.last <= last;
		end
	end

endmodule

[sv/clsc_queue.sv]
// short queue of classified words between front and back
module clsc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  clsc_pkg::item_t  wr_item,
	input  logic             pop,
	output clsc_pkg::item_t  rd_item,
	output clsc_pkg::qstat_t qstat
);

	clsc_pkg::item_t             slot_q [clsc_pkg::QDEPTH];
	logic [clsc_pkg::QAW-1:0]    wr_ptr_q;
	logic [clsc_pkg::QAW-1:0]    rd_ptr_q;
	logic [clsc_pkg::QAW:0]      count_q;

	assign qstat.full  = (count_q == (clsc_pkg::QAW+1)'(clsc_pkg::QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign rd_item     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

[sv/clsc_back.sv]
// back stage: recognizer state machine and result register
module clsc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  clsc_pkg::item_t  rd_item,
	input  clsc_pkg::qstat_t qstat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             valid_res,
	output logic             line_end
);

	clsc_pkg::state_t state_q;
	clsc_pkg::state_t ns;
	clsc_pkg::state_t state_d;
	logic             out_valid_q;
	logic             valid_res_q;
	logic             line_end_q;
	logic             take;
	logic             ok;

	assign take = !qstat.empty && (!out_valid_q || !out_stall);
	assign pop  = take;

	// next state
	always_comb begin
		ns      = clsc_pkg::next_state(state_q, rd_item.cls);
		state_d = state_q;
		if (take) state_d = rd_item.last ? clsc_pkg::ST_LEAD : ns;
	end

	// outputs
	always_comb begin
		ok = (ns != clsc_pkg::ST_FAIL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= clsc_pkg::ST_LEAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= take || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			valid_res_q <= ok;
			line_end_q  <= rd_item.last;
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;
	assign line_end  = line_end_q;

endmodule

[sv/command_line_syntax_checker.sv]
// top level of the command line syntax checker
//
// takes one ascii character word per cycle (ch, with last marking the final
// character of a line) and returns one result word per character: valid_res
// is high while no syntax error has been seen in the line so far, and
// line_end echoes last, so valid_res on a word with line_end high is the
// verdict for the whole line. after the last character the recognizer goes
// back to its start state whatever the verdict. sustained rate is one word
// per cycle without stalls; an accepted input word passes the front class
// register, the queue and the back result register before its result word
// appears. the recognizer state register in the back stage closes a loop
// over the character class, which is what fixes the rate. a four-entry
// queue lets the front keep taking words while the result side is stalled.
module command_line_syntax_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       valid_res,
	output logic       line_end
);

	// classified word leaving the front
	clsc_pkg::item_t  wr_item;
	// word at the head of the queue
	clsc_pkg::item_t  rd_item;
	// queue fill status seen by both sides
	clsc_pkg::qstat_t qstat;
	logic             push;
	logic             pop;

	// front: input register plus character classification
	clsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ch       (ch),
		.last     (last),
		.qstat    (qstat),
		.push     (push),
		.item     (wr_item)
	);

	// decoupling queue
	clsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.qstat   (qstat)
	);

	// back: recognizer and output register
	clsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_item   (rd_item),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.valid_res (valid_res),
		.line_end  (line_end)
	);

`ifndef SYNTH
	// never write a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue written while full");

	// never read an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

	// input stalls only while the queue is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> qstat.full)
		else $error("input stalled with room in queue");

	// a word popped always shows up at the output next cycle
	a_pop_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("popped word lost");
`endif

endmodule

[verif/tb.sv]
// self-checking testbench for the command line syntax checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// what one result word should carry
	typedef struct packed {
		logic ok;
		logic eol;
	} verdict_t;

	localparam int HOLD_CYCLES  = 60;  // long receiver hold-off for the fill-up test
	localparam int RANDOM_CHARS = 950; // where the random part stops sending
	localparam int DRAIN_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 6;   // slack for stray result words after the drain

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] ch        = 8'h00;
	logic       last      = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       valid_res;
	logic       line_end;

	// predicted result words, oldest first
	verdict_t verdict_q[$];
	// recognizer state as the predictor sees it
	clsc_pkg::state_t line_state = clsc_pkg::ST_LEAD;

	int          errors       = 0;
	int          chars_sent   = 0;
	int          words_seen   = 0;
	int          lines_passed = 0;
	int          lines_failed = 0;
	bit   [31:0] states_hit   = '0;

	// pacing controls shared between the stimulus and the two sides
	bit tx_steady = 1'b0; // sender offers back to back
	bit rx_steady = 1'b0; // receiver starts no new random stalls
	bit hold_req  = 1'b0; // ask the receiver for one long hold-off
	bit hold_over = 1'b0; // receiver has finished that hold-off

	command_line_syntax_checker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.valid_res (valid_res),
		.line_end  (line_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// one step of the recognizer, written straight from the character values
	function automatic clsc_pkg::state_t syntax_next(input clsc_pkg::state_t s,
		input logic [7:0] c);
		bit let_c;
		bit sp;
		let_c = is_letter(c);
		sp    = (c == clsc_pkg::CH_SPACE);
		case (s)
			clsc_pkg::ST_LEAD: begin
				if (sp) return clsc_pkg::ST_LEAD;
				return let_c ? clsc_pkg::ST_CMD : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_CMD: begin
				if (sp) return clsc_pkg::ST_GAP;
				return let_c ? clsc_pkg::ST_CMD : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_GAP: begin
				if (c == clsc_pkg::CH_DASH) return clsc_pkg::ST_OPT;
				if (sp) return clsc_pkg::ST_GAP;
				if (c == clsc_pkg::CH_PIPE) return clsc_pkg::ST_PIPE1;
				if (c == clsc_pkg::CH_LT) return clsc_pkg::ST_LT;
				if (c == clsc_pkg::CH_GT) return clsc_pkg::ST_GT;
				if (c == clsc_pkg::CH_AMP) return clsc_pkg::ST_AMP1;
				if (let_c) return clsc_pkg::ST_WORD;
				if (c == clsc_pkg::CH_DOT) return clsc_pkg::ST_DOT;
				if (c == clsc_pkg::CH_DOLLAR) return clsc_pkg::ST_VAR;
				return clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_OPTSEP: return sp ? clsc_pkg::ST_OPT : clsc_pkg::ST_FAIL;
			clsc_pkg::ST_OPT: begin
				if (sp) return clsc_pkg::ST_GAP;
				return let_c ? clsc_pkg::ST_OPT : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_AMP1: begin
				return (c == clsc_pkg::CH_AMP) ? clsc_pkg::ST_AMP2 : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_AMP2:   return sp ? clsc_pkg::ST_AMPSP : clsc_pkg::ST_FAIL;
			clsc_pkg::ST_AMPSP:  return let_c ? clsc_pkg::ST_AMPCMD : clsc_pkg::ST_FAIL;
			clsc_pkg::ST_AMPCMD: begin
				if (sp) return clsc_pkg::ST_GAP;
				return let_c ? clsc_pkg::ST_AMPCMD : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_PIPE1: begin
				if (sp) return clsc_pkg::ST_PIPESP;
				return (c == clsc_pkg::CH_PIPE) ? clsc_pkg::ST_PIPE2 : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_PIPE2:  return sp ? clsc_pkg::ST_PIPESP : clsc_pkg::ST_FAIL;
			clsc_pkg::ST_PIPESP: return let_c ? clsc_pkg::ST_WORD : clsc_pkg::ST_FAIL;
			clsc_pkg::ST_WORD: begin
				if (sp) return clsc_pkg::ST_GAP;
				if (c == clsc_pkg::CH_SLASH) return clsc_pkg::ST_PATH;
				if (let_c) return clsc_pkg::ST_WORD;
				return (c == clsc_pkg::CH_DOT) ? clsc_pkg::ST_EXT : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_PATH: begin
				if (let_c) return clsc_pkg::ST_PATH;
				return (c == clsc_pkg::CH_DOT) ? clsc_pkg::ST_EXT : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_EXT: begin
				if (let_c) return clsc_pkg::ST_EXT;
				return sp ? clsc_pkg::ST_GAP : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_RFILE: begin
				if (c == clsc_pkg::CH_DOT) return clsc_pkg::ST_FEXT;
				// a slash inside a redirect target keeps the state
				if (c == clsc_pkg::CH_SLASH || let_c) return clsc_pkg::ST_RFILE;
				return clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_RSP: return (sp || let_c) ? clsc_pkg::ST_RFILE : clsc_pkg::ST_FAIL;
			clsc_pkg::ST_LT: begin
				if (c == clsc_pkg::CH_LT) return clsc_pkg::ST_HDOC;
				return sp ? clsc_pkg::ST_RSP : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_GT: begin
				if (c == clsc_pkg::CH_GT) return clsc_pkg::ST_RSP;
				return sp ? clsc_pkg::ST_RFILE : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_HDOC: return sp ? clsc_pkg::ST_HDWORD : clsc_pkg::ST_FAIL;
			clsc_pkg::ST_HDWORD: begin
				if (c == clsc_pkg::CH_DOT) return clsc_pkg::ST_FEXT;
				return let_c ? clsc_pkg::ST_HDWORD : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_FEXT: return let_c ? clsc_pkg::ST_FEXT : clsc_pkg::ST_FAIL;
			clsc_pkg::ST_DOT: begin
				if (c == clsc_pkg::CH_DOT) return clsc_pkg::ST_DOTDOT;
				if (c == clsc_pkg::CH_SLASH) return clsc_pkg::ST_REL;
				return (sp || let_c) ? clsc_pkg::ST_GAP : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_DOTDOT: begin
				if (c == clsc_pkg::CH_SLASH) return clsc_pkg::ST_REL;
				return sp ? clsc_pkg::ST_GAP : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_REL: begin
				if (sp) return clsc_pkg::ST_GAP;
				return let_c ? clsc_pkg::ST_WORD : clsc_pkg::ST_FAIL;
			end
			clsc_pkg::ST_VAR: return let_c ? clsc_pkg::ST_WORD : clsc_pkg::ST_FAIL;
			// fail is sticky, and any stray code acts like it
			default: return clsc_pkg::ST_FAIL;
		endcase
	endfunction

	// queue the result word for one accepted character and advance the state
	task automatic predict_verdict(input logic [7:0] c, input logic fin);
		clsc_pkg::state_t nxt;
		verdict_t         v;
		nxt   = syntax_next(line_state, c);
		v.ok  = (nxt != clsc_pkg::ST_FAIL);
		v.eol = fin;
		verdict_q.push_back(v);
		states_hit[nxt] = 1'b1;
		if (fin) begin
			if (v.ok) lines_passed++;
			else lines_failed++;
		end
		// end of line always drops back to the leading space state
		line_state = fin ? clsc_pkg::ST_LEAD : nxt;
	endtask

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------

	// idle cycles before the next word: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (tx_steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// offer one character word and hold it until the block takes it
	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch       <= c;
		last     <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_verdict(c, fin);
		chars_sent++;
	endtask

	task automatic send_text(input string s, input bit fin);
		for (int i = 0; i < s.len(); i++) send_char(s[i], fin && (i == s.len() - 1));
	endtask

	task automatic send_line(ref logic [7:0] q[$]);
		for (int i = 0; i < q.size(); i++) send_char(q[i], i == q.size() - 1);
	endtask

	// ------------------------------------------------------------------
	// receiver side: random stalls plus one long counted hold-off
	// ------------------------------------------------------------------

	initial begin
		int stall_left;
		int hold_cnt;
		int r;
		bit nxt;
		stall_left = 0;
		hold_cnt   = 0;
		forever begin
			@(posedge clk);
			nxt = 1'b0;
			if (hold_req && !hold_over) begin
				if (hold_cnt == HOLD_CYCLES) begin
					hold_over = 1'b1;
					hold_cnt  = 0;
				end else begin
					hold_cnt++;
					nxt = 1'b1;
				end
			end else begin
				if (!hold_req) hold_over = 1'b0;
				if (stall_left > 0) begin
					stall_left--;
					nxt = 1'b1;
				end else if (!rx_steady) begin
					r = $urandom_range(0, 99);
					if (r >= 95) stall_left = $urandom_range(8, 30) - 1;
					else if (r >= 70) stall_left = $urandom_range(1, 3) - 1;
					nxt = (r >= 70);
				end
			end
			out_stall <= nxt;
		end
	end

	// ------------------------------------------------------------------
	// result checker: every accepted result word against the oldest prediction
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			words_seen++;
			if (verdict_q.size() == 0) begin
				$display("%0t: result word with nothing expected: valid_res=%0b line_end=%0b",
					$time, valid_res, line_end);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (valid_res !== want.ok) begin
					$display("%0t: valid_res mismatch: expected %0b, got %0b",
						$time, want.ok, valid_res);
					errors++;
				end
				if (line_end !== want.eol) begin
					$display("%0t: line_end mismatch: expected %0b, got %0b",
						$time, want.eol, line_end);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// random line building
	// ------------------------------------------------------------------

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
	endfunction

	task automatic add_letters(ref logic [7:0] q[$], input int lo, input int hi);
		repeat ($urandom_range(lo, hi)) q.push_back(rand_letter());
	endtask

	// target of a redirection: letters, maybe a slash part, maybe an extension
	task automatic add_file_name(ref logic [7:0] q[$]);
		add_letters(q, 1, 3);
		if ($urandom_range(0, 1)) begin
			q.push_back(clsc_pkg::CH_SLASH);
			add_letters(q, 0, 2);
		end
		if ($urandom_range(0, 1)) begin
			q.push_back(clsc_pkg::CH_DOT);
			add_letters(q, 0, 2);
		end
	endtask

	// redirections leave a state that rejects a space, so one is always the last segment
	task automatic add_redirect(ref logic [7:0] q[$]);
		case ($urandom_range(0, 3))
			0: begin
				q.push_back(clsc_pkg::CH_GT);
				q.push_back(clsc_pkg::CH_SPACE);
				add_file_name(q);
			end
			1: begin
				q.push_back(clsc_pkg::CH_GT);
				q.push_back(clsc_pkg::CH_GT);
				if ($urandom_range(0, 1)) q.push_back(clsc_pkg::CH_SPACE);
				add_file_name(q);
			end
			2: begin
				q.push_back(clsc_pkg::CH_LT);
				q.push_back(clsc_pkg::CH_SPACE);
				if ($urandom_range(0, 1)) q.push_back(clsc_pkg::CH_SPACE);
				add_file_name(q);
			end
			default: begin
				// here-document word
				q.push_back(clsc_pkg::CH_LT);
				q.push_back(clsc_pkg::CH_LT);
				q.push_back(clsc_pkg::CH_SPACE);
				add_letters(q, 0, 3);
				if ($urandom_range(0, 1)) begin
					q.push_back(clsc_pkg::CH_DOT);
					add_letters(q, 0, 2);
				end
			end
		endcase
	endtask

	// relative path forms starting with a dot
	task automatic add_dot_path(ref logic [7:0] q[$]);
		q.push_back(clsc_pkg::CH_DOT);
		case ($urandom_range(0, 4))
			0: ;
			1: q.push_back(clsc_pkg::CH_DOT);
			2: begin
				q.push_back(clsc_pkg::CH_SLASH);
				add_letters(q, 0, 2);
			end
			3: begin
				q.push_back(clsc_pkg::CH_DOT);
				q.push_back(clsc_pkg::CH_SLASH);
				add_letters(q, 0, 2);
			end
			default: q.push_back(rand_letter());
		endcase
	endtask

	// random command line, well-formed unless a space follows a redirection
	task automatic build_command(ref logic [7:0] q[$]);
		int nseg;
		q.delete();
		repeat ($urandom_range(0, 2)) q.push_back(clsc_pkg::CH_SPACE);
		add_letters(q, 1, 5);
		nseg = $urandom_range(0, 4);
		for (int i = 0; i < nseg; i++) begin
			q.push_back(clsc_pkg::CH_SPACE);
			if ($urandom_range(0, 4) == 0) q.push_back(clsc_pkg::CH_SPACE);
			case ($urandom_range(0, 10))
				0: begin
					q.push_back(clsc_pkg::CH_DASH);
					add_letters(q, 0, 3);
				end
				1: add_letters(q, 1, 4);
				2: begin
					add_letters(q, 1, 3);
					q.push_back(clsc_pkg::CH_DOT);
					add_letters(q, 0, 2);
				end
				3: begin
					// path must close with an extension before a space
					add_letters(q, 1, 3);
					q.push_back(clsc_pkg::CH_SLASH);
					add_letters(q, 0, 2);
					q.push_back(clsc_pkg::CH_DOT);
					add_letters(q, 0, 2);
				end
				4: begin
					q.push_back(clsc_pkg::CH_PIPE);
					if ($urandom_range(0, 1)) q.push_back(clsc_pkg::CH_PIPE);
					q.push_back(clsc_pkg::CH_SPACE);
					add_letters(q, 1, 3);
				end
				5: begin
					q.push_back(clsc_pkg::CH_AMP);
					q.push_back(clsc_pkg::CH_AMP);
					q.push_back(clsc_pkg::CH_SPACE);
					add_letters(q, 1, 3);
				end
				6: add_dot_path(q);
				7: begin
					q.push_back(clsc_pkg::CH_DOLLAR);
					add_letters(q, 1, 3);
				end
				default: begin
					add_redirect(q);
					i = nseg;
				end
			endcase
		end
		if ($urandom_range(0, 5) == 0 && q[q.size() - 1] != clsc_pkg::CH_SPACE) begin
			q.push_back(clsc_pkg::CH_SPACE);
		end
	endtask

	// short line of random bytes: a quarter syntax characters, half letters
	task automatic build_noise(ref logic [7:0] q[$]);
		string marks;
		marks = " |&<>$./-";
		q.delete();
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 3))
				0: q.push_back(8'($urandom_range(0, 255)));
				1: q.push_back(marks[$urandom_range(0, marks.len() - 1)]);
				default: q.push_back(rand_letter());
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// hand-picked lines for the corner cases
	task automatic test_directed();
		// nul in the middle does not close the line, and the failure sticks
		send_char(8'h00, 1'b0);
		send_char("a", 1'b1);
		// bytes from the top half of the range
		send_char(8'hFF, 1'b1);
		send_char(8'h80, 1'b1);
		// slash inside a redirection target is accepted
		send_text("a > x/y", 1'b1);
		// error on the final character rejects the line
		send_text("a!", 1'b1);
		// next line starts clean after a rejected one
		send_text("Z", 1'b1);
		send_text("z && Ab", 1'b1);
	endtask

	// receiver holds off long enough for the queue to fill and stall the input
	task automatic test_backpressure();
		tx_steady = 1'b1;
		hold_req  = 1'b1;
		send_text("ls -al | grep x >> out.txt", 1'b1);
		wait (hold_over);
		hold_req  = 1'b0;
		tx_steady = 1'b0;
	endtask

	// mostly well-formed lines with random content, some broken, some noise
	task automatic test_random_lines();
		logic [7:0] line_q[$];
		int         r;
		while (chars_sent < RANDOM_CHARS) begin
			// now and then a stretch where neither side idles
			r = $urandom_range(0, 7);
			tx_steady = (r == 0);
			rx_steady = (r == 0);
			r = $urandom_range(0, 99);
			if (r < 12) begin
				build_noise(line_q);
			end else begin
				build_command(line_q);
				// break a well-formed line at one random spot
				if (r < 24) line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
				else if (r < 28 && line_q.size() > 1) line_q = line_q[0:$urandom_range(0, line_q.size() - 2)];
			end
			send_line(line_q);
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// let every predicted word come out, then a few more cycles for strays
	task automatic wait_drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (verdict_q.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (verdict_q.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, verdict_q.size());
			errors += verdict_q.size();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_lines();
		wait_drain();
		$display("sent %0d characters, checked %0d result words over %0d lines",
			chars_sent, words_seen, lines_passed + lines_failed);
		$display("%0d lines accepted, %0d rejected, %0d recognizer states entered",
			lines_passed, lines_failed, $countones(states_hit));
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
